[sv/mep_pkg.sv]
package mep_pkg;

	localparam logic [7:0] RT_CLOCK    = 8'hF8;
	localparam logic [7:0] RT_START    = 8'hFA;
	localparam logic [7:0] RT_CONTINUE = 8'hFB;
	localparam logic [7:0] RT_STOP     = 8'hFC;
	localparam logic [7:0] STATUS_MIN  = 8'h80;
	localparam logic [7:0] COMMON_MIN  = 8'hF0;
	localparam logic [7:0] NO_STATUS   = 8'hFF;

	localparam logic [1:0] LEN_ONE   = 2'd1;
	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	typedef struct packed {
		logic [7:0] status;
		logic [6:0] first;
		logic [6:0] second;
		logic [1:0] len;
	} msg_t;

	typedef struct packed {
		logic load;
		msg_t msg;
	} stage_t;

	// data bytes per voice status, indexed by status bits 6..4
	function automatic logic [1:0] voice_len(input logic [2:0] idx);
		logic [1:0] n;
		unique case (idx)
			3'd4, 3'd5: n = 2'd1;
			default:    n = 2'd2;
		endcase
		return n;
	endfunction

endpackage

[sv/mep_byte_if.sv]
interface mep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

[sv/mep_msg_if.sv]
interface mep_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] msg_status;
	logic [6:0] msg_first;
	logic [6:0] msg_second;
	logic [1:0] msg_len;

	modport source(output valid, output msg_status, output msg_first,
		output msg_second, output msg_len, input ready);
	modport sink(input valid, input msg_status, input msg_first,
		input msg_second, input msg_len, output ready);
endinterface

[sv/mep_parse.sv]
module mep_parse (
	input  logic            clk,
	input  logic            arst_n,
	mep_byte_if.sink        rx,
	input  logic            out_free,
	output mep_pkg::stage_t stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] status_q;
	logic       have_first_q;
	logic [6:0] held_first_q;

	logic advance;
	logic is_rt;
	logic rt_pass;
	logic is_status;
	logic voice_ok;
	logic need_one;

	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
		end
	end

	assign is_rt     = byte_s1 >= mep_pkg::RT_CLOCK;
	assign rt_pass   = byte_s1 == mep_pkg::RT_CLOCK || byte_s1 == mep_pkg::RT_START ||
		byte_s1 == mep_pkg::RT_CONTINUE || byte_s1 == mep_pkg::RT_STOP;
	assign is_status = byte_s1 >= mep_pkg::STATUS_MIN;
	assign voice_ok  = status_q >= mep_pkg::STATUS_MIN && status_q < mep_pkg::COMMON_MIN;
	assign need_one  = mep_pkg::voice_len(status_q[6:4]) == mep_pkg::LEN_ONE;

	always_comb begin
		stage.load       = 1'b0;
		stage.msg.status = status_q;
		stage.msg.first  = 7'd0;
		stage.msg.second = 7'd0;
		stage.msg.len    = mep_pkg::LEN_ONE;
		priority if (is_rt) begin
			stage.load       = advance && rt_pass;
			stage.msg.status = byte_s1;
		end else if (is_status) begin
			stage.load = 1'b0;
		end else if (voice_ok) begin
			if (need_one) begin
				stage.load      = advance;
				stage.msg.first = byte_s1[6:0];
				stage.msg.len   = mep_pkg::LEN_TWO;
			end else if (have_first_q) begin
				stage.load       = advance;
				stage.msg.first  = held_first_q;
				stage.msg.second = byte_s1[6:0];
				stage.msg.len    = mep_pkg::LEN_THREE;
			end
		end else begin
			// data byte with no voice status: dropped
			stage.load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= mep_pkg::NO_STATUS;
			have_first_q <= 1'b0;
			held_first_q <= 7'd0;
		end else if (advance && !is_rt) begin
			if (is_status) begin
				status_q     <= byte_s1;
				have_first_q <= 1'b0;
			end else if (voice_ok) begin
				if (need_one || have_first_q) begin
					have_first_q <= 1'b0;
				end else begin
					held_first_q <= byte_s1[6:0];
					have_first_q <= 1'b1;
				end
			end
		end
	end

endmodule

[sv/mep_out_reg.sv]
module mep_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  mep_pkg::stage_t stage,
	output logic            out_free,
	mep_msg_if.source       msg
);

	logic          valid_q;
	mep_pkg::msg_t msg_q;

	assign out_free = !valid_q || msg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (stage.load) begin
			valid_q <= 1'b1;
		end else if (msg.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stage.load) begin
			msg_q <= stage.msg;
		end
	end

	assign msg.valid      = valid_q;
	assign msg.msg_status = msg_q.status;
	assign msg.msg_first  = msg_q.first;
	assign msg.msg_second = msg_q.second;
	assign msg.msg_len    = msg_q.len;

endmodule

[sv/midi_event_parser.sv]
// channel | dir | beat payload
// rx      | in  | in_byte[7:0]
// msg     | out | msg_status[7:0] msg_first[6:0] msg_second[6:0] msg_len[1:0]
//
// One byte per cycle while msg is not stalled; a byte reaches msg via the input register, then the output register.
// The path is an input register, one level of decode, and the output register.
// arst_n clears the pipeline, the running status (to none) and the data count.
// A stall on msg holds the input register; rx.ready drops only while both are full.
module midi_event_parser (
	input  logic      clk,
	input  logic      arst_n,
	mep_byte_if.sink  rx,
	mep_msg_if.source msg
);

	mep_pkg::stage_t stage;
	logic            out_free;

	mep_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.out_free (out_free),
		.stage    (stage)
	);

	mep_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.stage    (stage),
		.out_free (out_free),
		.msg      (msg)
	);

endmodule

[sv/mep_checker.sv]
module mep_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       msg_valid,
	input logic       msg_ready,
	input logic [7:0] msg_status,
	input logic [6:0] msg_first,
	input logic [6:0] msg_second,
	input logic [1:0] msg_len
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> msg_valid)
		else $error("msg valid dropped under stall");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_ready |=> $stable(msg_status) && $stable(msg_len) &&
		$stable(msg_first) && $stable(msg_second))
		else $error("msg beat changed under stall");

	a_realtime: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_len == mep_pkg::LEN_ONE |->
		(msg_status == mep_pkg::RT_CLOCK || msg_status == mep_pkg::RT_START ||
		msg_status == mep_pkg::RT_CONTINUE || msg_status == mep_pkg::RT_STOP) &&
		msg_first == 7'd0 && msg_second == 7'd0)
		else $error("bad realtime beat");

	a_voice: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_len != mep_pkg::LEN_ONE |->
		msg_len != 2'd0 && msg_status[7] && msg_status < mep_pkg::COMMON_MIN &&
		((mep_pkg::voice_len(msg_status[6:4]) == mep_pkg::LEN_ONE) ==
		(msg_len == mep_pkg::LEN_TWO)))
		else $error("voice length mismatch");

	a_two_byte: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_len == mep_pkg::LEN_TWO |-> msg_second == 7'd0)
		else $error("stray second data byte");

endmodule

bind midi_event_parser mep_checker u_mep_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.msg_valid  (msg.valid),
	.msg_ready  (msg.ready),
	.msg_status (msg.msg_status),
	.msg_first  (msg.msg_first),
	.msg_second (msg.msg_second),
	.msg_len    (msg.msg_len)
);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam logic [2:0] NIB_PROGRAM  = 3'd4;
	localparam logic [2:0] NIB_PRESSURE = 3'd5;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned HOLD_AFTER  = 150;

	typedef struct {
		logic [7:0] b;
		bit         sync;
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mep_byte_if rx_bus();
	mep_msg_if  msg_bus();

	midi_event_parser i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_bus),
		.msg   (msg_bus)
	);

	always #6 clk = ~clk;

	pending_t      rx_bytes[$];
	mep_pkg::msg_t expected_msgs[$];
	bit            sync_next = 1'b0;
	int unsigned   errors = 0;

	// parser state mirror
	logic [7:0] run_status = mep_pkg::NO_STATUS;
	logic [1:0] data_cnt   = 2'd0;
	logic [6:0] first_held = 7'd0;

	function void add_byte(input logic [7:0] b);
		pending_t p;
		p.b = b;
		p.sync = sync_next;
		sync_next = 1'b0;
		rx_bytes.push_back(p);
	endfunction

	function void parse_byte(input logic [7:0] b);
		mep_pkg::msg_t m;
		logic [1:0] need;
		m = '0;
		if (b >= mep_pkg::RT_CLOCK) begin
			if (b == mep_pkg::RT_CLOCK || b == mep_pkg::RT_START ||
				b == mep_pkg::RT_CONTINUE || b == mep_pkg::RT_STOP) begin
				m.status = b;
				m.len = mep_pkg::LEN_ONE;
				expected_msgs.push_back(m);
			end
		end else if (b >= mep_pkg::STATUS_MIN) begin
			run_status = b;
			data_cnt = 2'd0;
		end else if (run_status >= mep_pkg::STATUS_MIN &&
			run_status < mep_pkg::COMMON_MIN) begin
			need = (run_status[6:4] == NIB_PROGRAM || run_status[6:4] == NIB_PRESSURE) ?
				2'd1 : 2'd2;
			m.status = run_status;
			if (need == 2'd1) begin
				data_cnt = 2'd0;
				m.first = b[6:0];
				m.len = mep_pkg::LEN_TWO;
				expected_msgs.push_back(m);
			end else if (data_cnt == 2'd0) begin
				first_held = b[6:0];
				data_cnt = 2'd1;
			end else begin
				data_cnt = 2'd0;
				m.first = first_held;
				m.second = b[6:0];
				m.len = mep_pkg::LEN_THREE;
				expected_msgs.push_back(m);
			end
		end
	endfunction

	// no gaps for the first 64 of every 192 phase values, otherwise mostly short gaps
	function int unsigned idle_len(input int unsigned phase);
		int unsigned r;
		if ((phase / 64) % 3 == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		errors++;
	endtask

	// driver
	pending_t    next_byte;
	int unsigned tx_gap = 0;
	int unsigned tx_beats = 0;

	initial begin
		rx_bus.valid = 1'b0;
		rx_bus.in_byte = 8'h00;
		msg_bus.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_bus.valid && rx_bus.ready) begin
				parse_byte(rx_bus.in_byte);
				tx_beats++;
			end
			if (rx_bus.valid && !rx_bus.ready) begin
				// hold the offered beat
			end else if (tx_gap > 0) begin
				tx_gap--;
				rx_bus.valid <= 1'b0;
			end else if (rx_bytes.size() > 0 &&
				!(rx_bytes[0].sync && expected_msgs.size() != 0)) begin
				next_byte = rx_bytes.pop_front();
				rx_bus.valid <= 1'b1;
				rx_bus.in_byte <= next_byte.b;
				tx_gap = idle_len(tx_beats);
			end else begin
				rx_bus.valid <= 1'b0;
			end
		end
	end

	// monitor
	mep_pkg::msg_t want_msg;
	int unsigned   rx_hold = 0;
	int unsigned   msg_beats = 0;
	int unsigned   mon_cycles = 0;
	bit            long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			mon_cycles++;
			if (msg_bus.valid && msg_bus.ready) begin
				msg_beats++;
				if (expected_msgs.size() == 0) begin
					report_mismatch($sformatf("unexpected message status %h len %0d",
						msg_bus.msg_status, msg_bus.msg_len));
				end else begin
					want_msg = expected_msgs.pop_front();
					if (msg_bus.msg_status !== want_msg.status)
						report_mismatch($sformatf("msg_status %h, expected %h",
							msg_bus.msg_status, want_msg.status));
					if (msg_bus.msg_first !== want_msg.first)
						report_mismatch($sformatf("msg_first %h, expected %h (status %h)",
							msg_bus.msg_first, want_msg.first, want_msg.status));
					if (msg_bus.msg_second !== want_msg.second)
						report_mismatch($sformatf("msg_second %h, expected %h (status %h)",
							msg_bus.msg_second, want_msg.second, want_msg.status));
					if (msg_bus.msg_len !== want_msg.len)
						report_mismatch($sformatf("msg_len %0d, expected %0d (status %h)",
							msg_bus.msg_len, want_msg.len, want_msg.status));
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				msg_bus.ready <= 1'b0;
			end else if (!long_hold_done && msg_beats >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				rx_hold = LONG_HOLD - 1;
				msg_bus.ready <= 1'b0;
			end else begin
				rx_hold = idle_len(mon_cycles + 32);
				if (rx_hold > 0) begin
					rx_hold--;
					msg_bus.ready <= 1'b0;
				end else begin
					msg_bus.ready <= 1'b1;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		int unsigned kind;
		int unsigned groups;
		int unsigned n;
		logic [7:0]  st;
		bit          mid_sync;

		mid_sync = 1'b0;

		// no status yet, then realtime bytes
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(mep_pkg::RT_CLOCK);
		add_byte(8'hF9);
		add_byte(mep_pkg::RT_START);
		add_byte(mep_pkg::RT_CONTINUE);
		add_byte(mep_pkg::RT_STOP);
		add_byte(8'hFD);
		add_byte(8'hFE);
		add_byte(mep_pkg::NO_STATUS);
		// note on, then running status
		add_byte(8'h90);
		add_byte(8'h40);
		add_byte(8'h7F);
		add_byte(8'h01);
		add_byte(8'h02);
		// program change
		add_byte(8'hC5);
		add_byte(8'h7F);
		// system common cancels running status
		add_byte(8'hF3);
		add_byte(8'h12);
		// realtime inside a message
		add_byte(8'h80);
		add_byte(8'h3C);
		add_byte(mep_pkg::RT_CLOCK);
		add_byte(8'h00);
		// channel pressure
		add_byte(8'hD7);
		add_byte(8'h55);

		sync_next = 1'b1;
		while (rx_bytes.size() < 960) begin
			if (!mid_sync && rx_bytes.size() >= 500) begin
				mid_sync = 1'b1;
				sync_next = 1'b1;
			end
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
				add_byte(st);
				groups = $urandom_range(1, 4);
				n = (st[6:4] == NIB_PROGRAM || st[6:4] == NIB_PRESSURE) ? 1 : 2;
				repeat (groups * n) begin
					if ($urandom_range(0, 9) == 0)
						add_byte(8'($urandom_range(mep_pkg::RT_CLOCK, mep_pkg::NO_STATUS)));
					add_byte(8'($urandom_range(0, 127)));
				end
			end else if (kind < 80) begin
				add_byte(8'($urandom_range(mep_pkg::COMMON_MIN, 8'hF7)));
				repeat ($urandom_range(0, 3))
					add_byte(8'($urandom_range(0, 127)));
			end else if (kind < 90) begin
				add_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom)});
				repeat ($urandom_range(0, 1))
					add_byte(8'($urandom_range(0, 127)));
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_bytes.size() != 0 || rx_bus.valid)
			@(posedge clk);
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("testbench failed");
		$finish;
	end

endmodule
